// ----- hw/rtl/pcosr_pkg.sv -----
// Shared types, widths and codes for the phase-current offset and scale front end.
package pcosr_pkg;

  // Channel count and converter resolution are fixed by the item fields.
  localparam int CHANNELS   = 4;
  localparam int ADC_BITS   = 12;
  localparam int LANE_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Datapath widths.
  localparam int FRAC_BITS   = 8;
  localparam int SUM_W       = 28;
  localparam int OFS_W       = ADC_BITS + FRAC_BITS;
  localparam int CS_W        = 16;
  localparam int MS_W        = 16;
  localparam int SCALE_W     = 24;
  localparam int CNT_W       = 32;
  localparam int AMPS_W      = 24;
  localparam int DIFF_W      = ADC_BITS + FRAC_BITS + 1;
  localparam int PROD_W      = DIFF_W + SCALE_W + 1;
  localparam int ROUND_SHIFT = 22;
  localparam int DIVD_W      = SUM_W + FRAC_BITS + 1;
  localparam int DIV_CNT_W   = $clog2(DIVD_W);
  localparam int ACT_W       = 3;
  localparam int MODE_W      = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CALIB_SAMPLES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RAIL_LOW      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RAIL_HIGH     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_AMPS_SCALE    = CFG_IDX_W'(4);

  localparam logic [CS_W-1:0]     RST_CALIB_SAMPLES = CS_W'(1000);
  localparam logic [MS_W-1:0]     RST_TIMEOUT_MS    = MS_W'(1000);
  localparam logic [ADC_BITS-1:0] RST_RAIL_LOW      = ADC_BITS'(16);
  localparam logic [ADC_BITS-1:0] RST_RAIL_HIGH     = ADC_BITS'(4079);
  localparam logic [SCALE_W-1:0]  RST_AMPS_SCALE    = SCALE_W'(480000);

  // Request action codes.
  localparam logic [ACT_W-1:0] ACT_CALIB = ACT_W'(0);
  localparam logic [ACT_W-1:0] ACT_CONT  = ACT_W'(1);
  localparam logic [ACT_W-1:0] ACT_SET   = ACT_W'(2);
  localparam logic [ACT_W-1:0] ACT_STOP  = ACT_W'(3);
  localparam logic [ACT_W-1:0] ACT_TICK  = ACT_W'(4);

  typedef enum logic [MODE_W-1:0] {
    MODE_UNINIT  = 3'd0,
    MODE_IDLE    = 3'd1,
    MODE_CALIB   = 3'd2,
    MODE_CONT    = 3'd3,
    MODE_SYNCERR = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_TAKE,
    ST_EXEC,
    ST_MUL,
    ST_DRAIN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [CS_W-1:0]     calib_samples;
    logic [MS_W-1:0]     timeout_ms;
    logic [ADC_BITS-1:0] rail_low;
    logic [ADC_BITS-1:0] rail_high;
    logic [SCALE_W-1:0]  amps_scale;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic              capture;
    logic              exec;
    logic              mul_en;
    logic              div_start;
    logic              load_out;
    logic [LANE_W-1:0] lane;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_mul;
    logic need_div;
    logic div_done;
  } stat_t;

  typedef struct packed {
    logic                             current_valid;
    logic [CHANNELS-1:0][AMPS_W-1:0] amps;
    logic                             rail_hit;
    logic [CNT_W-1:0]                 sample_number;
    logic [MODE_W-1:0]                mode;
    logic                             calib_done;
  } result_t;

endpackage

// ----- hw/rtl/pcosr_if.sv -----
// Valid/ready channel interfaces for sample-set requests and current results.
interface pcosr_sample_if;
  import pcosr_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [ADC_BITS-1:0] raw_u1;
  logic [ADC_BITS-1:0] raw_v;
  logic [ADC_BITS-1:0] raw_u2;
  logic [ADC_BITS-1:0] raw_w;
  logic                slave_ready;

  modport source (output valid, action, raw_u1, raw_v, raw_u2, raw_w, slave_ready,
                  input ready);
  modport sink (input valid, action, raw_u1, raw_v, raw_u2, raw_w, slave_ready,
                output ready);
endinterface

interface pcosr_current_if;
  import pcosr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     current_valid;
  logic signed [AMPS_W-1:0] amps_u1;
  logic signed [AMPS_W-1:0] amps_v;
  logic signed [AMPS_W-1:0] amps_u2;
  logic signed [AMPS_W-1:0] amps_w;
  logic                     rail_hit;
  logic [CNT_W-1:0]         sample_number;
  logic [MODE_W-1:0]        mode;
  logic                     calib_done;

  modport source (output valid, current_valid, amps_u1, amps_v, amps_u2, amps_w, rail_hit,
                         sample_number, mode, calib_done,
                  input ready);
  modport sink (input valid, current_valid, amps_u1, amps_v, amps_u2, amps_w, rail_hit,
                      sample_number, mode, calib_done,
                output ready);
endinterface

// ----- hw/rtl/phase_current_offset_scale_rail.sv -----
// Top level of the four-channel phase-current offset calibration and scaling front end.
//
//   channel    dir  handshake        payload
//   samples    in   valid / ready    action, raw_u1, raw_v, raw_u2, raw_w, slave_ready
//   currents   out  valid / ready    current_valid, amps_u1..amps_w, rail_hit,
//                                    sample_number, mode, calib_done
//   cfg        in   cfg_we           cfg_index, cfg_data
//
// A request runs through capture, decode and result hand-off; a continuous-mode sample
// set also runs one channel per cycle through the single shared multiplier, plus
// one rounding step, and the set that ends a calibration runs the bit-serial divider
// per channel: 37 steps, started and then awaited for each channel in turn.
// Synchronous reset returns the mode to uninitialized, zeroes sums and offsets and
// restores the register defaults at once. A finished result waits in the output
// register while the next request is taken; only the hand-off of a second result
// waits for the first to be taken.
module phase_current_offset_scale_rail (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pcosr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcosr_pkg::CFG_DATA_W-1:0] cfg_data,
  pcosr_sample_if.sink                     samples,
  pcosr_current_if.source                  currents
);
  import pcosr_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  stat_t   stat;
  result_t result;

  pcosr_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcosr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .out_ready (currents.ready),
    .stat      (stat),
    .in_ready  (samples.ready),
    .out_valid (currents.valid),
    .cmd       (cmd)
  );

  // Channel order in the datapath: U1, V, U2, W.
  pcosr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .action_in (samples.action),
    .raw_in    ({samples.raw_w, samples.raw_u2, samples.raw_v, samples.raw_u1}),
    .slave_in  (samples.slave_ready),
    .result    (result)
  );

  assign currents.current_valid = result.current_valid;
  assign currents.amps_u1       = result.amps[0];
  assign currents.amps_v        = result.amps[1];
  assign currents.amps_u2       = result.amps[2];
  assign currents.amps_w        = result.amps[3];
  assign currents.rail_hit      = result.rail_hit;
  assign currents.sample_number = result.sample_number;
  assign currents.mode          = result.mode;
  assign currents.calib_done    = result.calib_done;

endmodule

// ----- hw/rtl/pcosr_regs.sv -----
// Configuration register bank written through the plain write port.
module pcosr_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pcosr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcosr_pkg::CFG_DATA_W-1:0] cfg_data,
  output pcosr_pkg::cfg_t                  cfg
);
  import pcosr_pkg::*;

  // Registers take the low bits of the write data; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.calib_samples <= RST_CALIB_SAMPLES;
      cfg.timeout_ms    <= RST_TIMEOUT_MS;
      cfg.rail_low      <= RST_RAIL_LOW;
      cfg.rail_high     <= RST_RAIL_HIGH;
      cfg.amps_scale    <= RST_AMPS_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CALIB_SAMPLES: cfg.calib_samples <= cfg_data[CS_W-1:0];
        REG_TIMEOUT_MS:    cfg.timeout_ms    <= cfg_data[MS_W-1:0];
        REG_RAIL_LOW:      cfg.rail_low      <= cfg_data[ADC_BITS-1:0];
        REG_RAIL_HIGH:     cfg.rail_high     <= cfg_data[ADC_BITS-1:0];
        REG_AMPS_SCALE:    cfg.amps_scale    <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/pcosr_div.sv -----
// Bit-serial restoring divider used to turn calibration sums into offsets.
module pcosr_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pcosr_pkg::DIVD_W-1:0] dividend,
  input  logic [pcosr_pkg::CS_W-1:0]   divisor,
  output logic                         done,
  output logic [pcosr_pkg::DIVD_W-1:0] quotient
);
  import pcosr_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CS_W-1:0]      rem;
  logic [DIVD_W-1:0]    dq;
  logic [CS_W:0]        trial;
  logic [CS_W:0]        trial_sub;
  logic                 fits;

  // One quotient bit per cycle: shift the next dividend bit into the remainder.
  always_comb begin
    trial     = {rem, dq[DIVD_W-1]};
    fits      = (trial >= {1'b0, divisor});
    trial_sub = trial - {1'b0, divisor};
  end

  // The dividend register fills with quotient bits from the bottom as it shifts.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dq   <= dividend;
      end else if (busy) begin
        rem <= fits ? trial_sub[CS_W-1:0] : trial[CS_W-1:0];
        dq  <= {dq[DIVD_W-2:0], fits};
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dq;

endmodule

// ----- hw/rtl/pcosr_datapath.sv -----
// Mode state, calibration sums, offsets, shared current multiplier and result register.
module pcosr_datapath (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  pcosr_pkg::cfg_t                                      cfg,
  input  pcosr_pkg::cmd_t                                      cmd,
  output pcosr_pkg::stat_t                                     stat,
  input  logic [pcosr_pkg::ACT_W-1:0]                          action_in,
  input  logic [pcosr_pkg::CHANNELS-1:0][pcosr_pkg::ADC_BITS-1:0] raw_in,
  input  logic                                                 slave_in,
  output pcosr_pkg::result_t                                   result
);
  import pcosr_pkg::*;

  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (ROUND_SHIFT - 1);

  // Captured request.
  logic [ACT_W-1:0]                   cap_action;
  logic [CHANNELS-1:0][ADC_BITS-1:0]  cap_raw;
  logic                               cap_slave;

  // Run state.
  mode_t                              run_mode, run_mode_next;
  logic [CHANNELS-1:0][SUM_W-1:0]     offset_sum, offset_sum_next;
  logic [CHANNELS-1:0][OFS_W-1:0]     offset_q8;
  logic [CNT_W-1:0]                   accepted_count, accepted_count_next;
  logic [MS_W-1:0]                    idle_ms, idle_ms_next;

  // Per-request working flags and currents.
  logic                               w_valid, w_valid_next;
  logic                               w_rails, w_rails_next;
  logic                               w_done, w_done_next;
  logic [CHANNELS-1:0][AMPS_W-1:0]    amps_w;

  // Multiplier stage.
  logic signed [DIFF_W-1:0]           diff;
  logic signed [PROD_W-1:0]           prod;
  logic [PROD_W-1:0]                  prod_rnd;
  logic [LANE_W-1:0]                  prod_lane;
  logic                               prod_vld;

  // Divider hookup.
  logic [CS_W-1:0]                    n_eff;
  logic [DIVD_W-1:0]                  dividend;
  logic [DIVD_W-1:0]                  quotient;
  logic                               div_done;

  logic [CNT_W-1:0]                   count_inc;
  logic [MS_W-1:0]                    idle_sat;
  logic                               rail_any;
  logic                               need_mul;
  logic                               need_div;

  // Capture the request on the accept edge.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_action <= action_in;
      cap_raw    <= raw_in;
      cap_slave  <= slave_in;
    end
  end

  // Decode the captured request against the current mode.
  always_comb begin
    n_eff     = (cfg.calib_samples == '0) ? CS_W'(1) : cfg.calib_samples;
    count_inc = accepted_count + CNT_W'(1);
    idle_sat  = (idle_ms == '1) ? idle_ms : idle_ms + MS_W'(1);
    rail_any  = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (cap_raw[i] < cfg.rail_low || cap_raw[i] > cfg.rail_high) begin
        rail_any = 1'b1;
      end
    end

    run_mode_next       = run_mode;
    offset_sum_next     = offset_sum;
    accepted_count_next = accepted_count;
    idle_ms_next        = idle_ms;
    w_valid_next        = 1'b0;
    w_rails_next        = 1'b0;
    w_done_next         = 1'b0;
    need_mul            = 1'b0;
    need_div            = 1'b0;

    case (cap_action)
      ACT_CALIB: begin
        if (run_mode == MODE_UNINIT || run_mode == MODE_IDLE) begin
          offset_sum_next     = '0;
          accepted_count_next = '0;
          idle_ms_next        = '0;
          run_mode_next       = MODE_CALIB;
        end
      end
      ACT_CONT: begin
        if (run_mode == MODE_IDLE) begin
          accepted_count_next = '0;
          idle_ms_next        = '0;
          run_mode_next       = MODE_CONT;
        end
      end
      ACT_SET: begin
        if (run_mode == MODE_CALIB || run_mode == MODE_CONT) begin
          if (!cap_slave) begin
            // A set without the second converter ends the run.
            run_mode_next = (run_mode == MODE_CALIB) ? MODE_UNINIT : MODE_SYNCERR;
          end else begin
            w_rails_next        = rail_any;
            accepted_count_next = count_inc;
            if (run_mode == MODE_CALIB) begin
              for (int i = 0; i < CHANNELS; i++) begin
                offset_sum_next[i] = offset_sum[i] + SUM_W'(cap_raw[i]);
              end
              if (count_inc >= CNT_W'(n_eff)) begin
                run_mode_next = MODE_IDLE;
                w_done_next   = 1'b1;
                need_div      = 1'b1;
              end
            end else begin
              idle_ms_next = '0;
              w_valid_next = 1'b1;
              need_mul     = 1'b1;
            end
          end
        end
      end
      ACT_STOP: begin
        if (run_mode == MODE_CALIB) begin
          run_mode_next = MODE_UNINIT;
        end else if (run_mode == MODE_CONT || run_mode == MODE_SYNCERR) begin
          run_mode_next = MODE_IDLE;
        end
      end
      ACT_TICK: begin
        if (run_mode == MODE_CALIB || run_mode == MODE_CONT) begin
          idle_ms_next = idle_sat;
          if (idle_sat >= cfg.timeout_ms) begin
            run_mode_next = (run_mode == MODE_CALIB) ? MODE_UNINIT : MODE_SYNCERR;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.need_mul = need_mul;
  assign stat.need_div = need_div;
  assign stat.div_done = div_done;

  // Run state update; offsets are written lane by lane as the divider finishes.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode       <= MODE_UNINIT;
      offset_sum     <= '0;
      offset_q8      <= '0;
      accepted_count <= '0;
      idle_ms        <= '0;
    end else begin
      if (cmd.exec) begin
        run_mode       <= run_mode_next;
        offset_sum     <= offset_sum_next;
        accepted_count <= accepted_count_next;
        idle_ms        <= idle_ms_next;
      end
      if (div_done) begin
        offset_q8[cmd.lane] <= quotient[OFS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      w_valid <= w_valid_next;
      w_rails <= w_rails_next;
      w_done  <= w_done_next;
    end
  end

  // Offset dividend is sum * 256 plus half the sample count, for round to nearest.
  assign dividend = {1'b0, offset_sum[cmd.lane], FRAC_BITS'(0)} + DIVD_W'(n_eff >> 1);

  pcosr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (n_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // One channel per cycle through the shared multiplier.
  assign diff = $signed({1'b0, cap_raw[cmd.lane], FRAC_BITS'(0)}) -
                $signed({1'b0, offset_q8[cmd.lane]});

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod      <= diff * $signed({1'b0, cfg.amps_scale});
      prod_lane <= cmd.lane;
    end
  end

  // Round half away from zero. The shifted product always fits the 24-bit
  // output range, so no saturation is applied.
  assign prod_rnd = prod + (prod[PROD_W-1] ? (RND_HALF - PROD_W'(1)) : RND_HALF);

  always_ff @(posedge clk) begin
    if (prod_vld) begin
      amps_w[prod_lane] <= prod_rnd[PROD_W-1:ROUND_SHIFT];
    end
  end

  // Output register; currents read as zero unless this was a continuous set.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.current_valid <= w_valid;
      result.amps          <= w_valid ? amps_w : '0;
      result.rail_hit      <= w_rails;
      result.sample_number <= accepted_count;
      result.mode          <= run_mode;
      result.calib_done    <= w_done;
    end
  end

  // The offset pass only runs after a calibration that has just finished.
  a_div_mode: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (run_mode == MODE_IDLE))
    else $error("offset divider finished outside idle mode");

  // Currents are only computed in continuous mode.
  a_mul_mode: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_en |-> (run_mode == MODE_CONT))
    else $error("current multiply issued outside continuous mode");

  // A continuous set bumps the sample count by exactly one.
  a_cont_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && need_mul) |=>
      (w_valid && accepted_count == $past(accepted_count) + CNT_W'(1)))
    else $error("continuous set did not advance the sample count");

endmodule

// ----- hw/rtl/pcosr_ctrl.sv -----
// Sequencer for capture, decode, per-channel multiply and divide passes, and result hand-off.
module pcosr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_ready,
  input  pcosr_pkg::stat_t stat,
  output logic             in_ready,
  output logic             out_valid,
  output pcosr_pkg::cmd_t  cmd
);
  import pcosr_pkg::*;

  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(CHANNELS - 1);

  state_t            state, state_next;
  logic [LANE_W-1:0] lane, lane_next;
  logic              res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_TAKE;
      lane  <= '0;
    end else begin
      state <= state_next;
      lane  <= lane_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    lane_next  = lane;
    cmd        = '0;
    cmd.lane   = lane;
    in_ready   = 1'b0;
    case (state)
      ST_TAKE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        lane_next = '0;
        if (stat.need_mul) begin
          state_next = ST_MUL;
        end else if (stat.need_div) begin
          state_next = ST_DIV_GO;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        if (lane == LAST_LANE) begin
          state_next = ST_DRAIN;
        end else begin
          lane_next = lane + LANE_W'(1);
        end
      end
      ST_DRAIN: begin
        state_next = ST_EMIT;
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          if (lane == LAST_LANE) begin
            state_next = ST_EMIT;
          end else begin
            lane_next  = lane + LANE_W'(1);
            state_next = ST_DIV_GO;
          end
        end
      end
      ST_EMIT: begin
        if (!res_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_TAKE;
        end
      end
      default: begin
        state_next = ST_TAKE;
      end
    endcase
  end

  // Output register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  assign out_valid = res_valid;

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!res_valid || out_ready))
    else $error("result register overwritten while still pending");

  // An accepted request is decoded on the very next cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_EXEC))
    else $error("accepted request was not decoded");

  // The divider only reports completion while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == ST_DIV_WAIT))
    else $error("divider finished while not awaited");

endmodule
